// File: rtl/core/assert_macros.svh
// Assertion macros shared by the RTL of the column peak finder
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every rising clock edge outside reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (prop)) else $error(msg);

// Check that a condition implies a consequence in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/cbrf_pkg.sv
// Package: sizes, register indexes and types of the column peak finder
`default_nettype none

package cbrf_pkg;

    localparam int MAX_COLS = 2048;
    localparam int MAX_ROWS = 2048;

    localparam int COL_W  = $clog2(MAX_COLS);
    localparam int ROW_W  = $clog2(MAX_ROWS);
    localparam int SUM_W  = 10;
    localparam int SIZE_W = 12;
    localparam int CHAN_W = 8;

    localparam logic [SIZE_W-1:0] WIDTH_RST  = SIZE_W'(640);
    localparam logic [SIZE_W-1:0] HEIGHT_RST = SIZE_W'(480);

    // Configuration register indexes
    typedef enum logic [0:0] {
        REG_FRAME_WIDTH  = 1'b0,
        REG_FRAME_HEIGHT = 1'b1
    } t_cfg_reg;

    // One kept column entry
    typedef struct packed {
        logic [ROW_W-1:0] row;
        logic [SUM_W-1:0] sum;
    } t_entry;

    // Write-back request into the column store
    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
        t_entry           data;
    } t_store_wr;

    // Read request into the column store
    typedef struct packed {
        logic             en;
        logic [COL_W-1:0] addr;
    } t_store_rd;

endpackage

`default_nettype wire

// File: rtl/core/cbrf_column_store.sv
// Column store: per-column best sum and row, registered read with write forwarding
`default_nettype none

module cbrf_column_store (
    input  wire logic              i_clk,
    input  wire logic              i_rst_n,
    input  wire cbrf_pkg::t_store_rd i_rd,
    input  wire cbrf_pkg::t_store_wr i_wr,
    output cbrf_pkg::t_entry       o_q
);
    import cbrf_pkg::*;

    t_entry mem [MAX_COLS];
    t_entry r_rd_data;
    t_entry r_fwd_data;
    logic   r_fwd;

    // Write back the updated entry
    always_ff @(posedge i_clk) begin
        if (i_wr.en) begin
            mem[i_wr.addr] <= i_wr.data;
        end
    end

    // Read on request; hold the data while no new request comes
    always_ff @(posedge i_clk) begin
        if (i_rd.en) begin
            r_rd_data  <= mem[i_rd.addr];
            r_fwd_data <= i_wr.data;
        end
    end

    // Forward a write that lands on the entry being read in the same cycle
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fwd <= 1'b0;
        end else if (i_rd.en) begin
            r_fwd <= i_wr.en && (i_wr.addr == i_rd.addr);
        end
    end

    assign o_q = r_fwd ? r_fwd_data : r_rd_data;

endmodule

`default_nettype wire

// File: rtl/core/column_brightest_row_finder_top.sv
// Top level: per-column brightest row search over a raster pixel stream
// A result passes through the stage 1 register and the output register before it reaches the master side.
// Throughput: one pixel per cycle; the column store is read and written back once
//   per pixel, with forwarding when the same column follows directly (width 1).
// Input stalls only while a result waits in the output register and is not taken.
// Reset (synchronous, active low) clears counters, pipeline and output valid and
//   sets width 640, height 480; the column store needs no clearing pass.
`default_nettype none
`include "assert_macros.svh"

module column_brightest_row_finder_top (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    // pixel requests
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [23:0] s_axis_tdata,   // [7:0] blue, [15:8] green, [23:16] red
    // column results
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [31:0]      m_axis_tdata,   // [10:0] column_index, [21:11] peak_row,
                                             // [31:22] peak_sum
    output logic             m_axis_tlast,   // frame_done
    // configuration writes
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [0:0]  i_cfg_index,
    input  wire logic [cbrf_pkg::SIZE_W-1:0] i_cfg_data
);
    import cbrf_pkg::*;

    logic [SIZE_W-1:0] r_width, r_height;
    logic [COL_W-1:0]  r_col, n_col;
    logic [ROW_W-1:0]  r_row, n_row;

    logic [COL_W-1:0]  cur_col;
    logic [ROW_W-1:0]  cur_row;
    logic [SUM_W-1:0]  pix_sum;
    logic              accept;

    logic              r_s1_valid;
    logic [COL_W-1:0]  r_s1_col;
    logic [ROW_W-1:0]  r_s1_row;
    logic [SUM_W-1:0]  r_s1_sum;
    logic              r_s1_row0, r_s1_last_row, r_s1_last_col;
    logic              s1_adv;

    t_entry            kept_q, base, upd;
    t_store_rd         st_rd;
    t_store_wr         st_wr;

    logic              r_out_valid;
    logic [COL_W-1:0]  r_out_col;
    t_entry            r_out_entry;
    logic              r_out_last;

    // Clamp a size write into 1..max
    function automatic logic [SIZE_W-1:0] clamp_size(input logic [SIZE_W-1:0] v,
                                                     input logic [SIZE_W-1:0] maxv);
        logic [SIZE_W-1:0] res;
        if (v == '0) begin
            res = SIZE_W'(1);
        end else if (v > maxv) begin
            res = maxv;
        end else begin
            res = v;
        end
        return res;
    endfunction

    // Configuration registers
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= WIDTH_RST;
            r_height <= HEIGHT_RST;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (t_cfg_reg'(i_cfg_index))
                REG_FRAME_WIDTH:  r_width  <= clamp_size(i_cfg_data, SIZE_W'(MAX_COLS));
                REG_FRAME_HEIGHT: r_height <= clamp_size(i_cfg_data, SIZE_W'(MAX_ROWS));
                default: ;
            endcase
        end
    end

    // Stage 0: position of the pixel, its sum and the next counter values
    always_comb begin
        cur_col = ({1'b0, r_col} >= r_width)  ? '0 : r_col;
        cur_row = ({1'b0, r_row} >= r_height) ? '0 : r_row;
        pix_sum = SUM_W'(s_axis_tdata[7:0]) + SUM_W'(s_axis_tdata[15:8])
                + SUM_W'(s_axis_tdata[23:16]);
        if (({1'b0, cur_col} + SIZE_W'(1)) >= r_width) begin
            n_col = '0;
            n_row = (({1'b0, cur_row} + SIZE_W'(1)) >= r_height) ? '0
                  : cur_row + ROW_W'(1);
        end else begin
            n_col = cur_col + COL_W'(1);
            n_row = cur_row;
        end
    end

    assign s1_adv        = r_s1_valid && (!r_s1_last_row || !r_out_valid || m_axis_tready);
    assign s_axis_tready = !r_s1_valid || s1_adv;
    assign accept        = s_axis_tvalid && s_axis_tready;

    // Advance the raster counters
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_col <= '0;
            r_row <= '0;
        end else if (accept) begin
            r_col <= n_col;
            r_row <= n_row;
        end
    end

    // Stage 1 control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid <= 1'b0;
        end else if (accept) begin
            r_s1_valid <= 1'b1;
        end else if (s1_adv) begin
            r_s1_valid <= 1'b0;
        end
    end

    // Stage 1 payload
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_s1_col      <= cur_col;
            r_s1_row      <= cur_row;
            r_s1_sum      <= pix_sum;
            r_s1_row0     <= (cur_row == '0);
            r_s1_last_row <= ({1'b0, cur_row} == (r_height - SIZE_W'(1)));
            r_s1_last_col <= ({1'b0, cur_col} == (r_width - SIZE_W'(1)));
        end
    end

    // Column store: read on accept, write back when stage 1 advances
    assign st_rd.en   = accept;
    assign st_rd.addr = cur_col;
    assign st_wr.en   = s1_adv;
    assign st_wr.addr = r_s1_col;
    assign st_wr.data = upd;

    cbrf_column_store u_store (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_rd    (st_rd),
        .i_wr    (st_wr),
        .o_q     (kept_q)
    );

    // Compare: the first row starts from a dark entry; replace only on a larger sum
    always_comb begin
        base = r_s1_row0 ? '0 : kept_q;
        if (r_s1_sum > base.sum) begin
            upd.sum = r_s1_sum;
            upd.row = r_s1_row;
        end else begin
            upd = base;
        end
    end

    // Output register control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (s1_adv && r_s1_last_row) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    // Output register payload
    always_ff @(posedge i_clk) begin
        if (s1_adv && r_s1_last_row) begin
            r_out_col   <= r_s1_col;
            r_out_entry <= upd;
            r_out_last  <= r_s1_last_col;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {r_out_entry.sum, r_out_entry.row, r_out_col};
    assign m_axis_tlast  = r_out_last;

    // The frame-end result belongs to the last column in use
    `ASSERT_IMPLY(a_last_col, i_clk, i_rst_n, r_out_valid && r_out_last, ({1'b0, r_out_col} == (r_width - SIZE_W'(1))), "frame_done on a column other than the last")
    // A peak sum never exceeds three full channels
    `ASSERT_IMPLY(a_sum_range, i_clk, i_rst_n, r_out_valid, (r_out_entry.sum <= SUM_W'(3 * ((1 << CHAN_W) - 1))), "peak sum above three full channels")
    // A dark column keeps row 0
    `ASSERT_IMPLY(a_dark_row0, i_clk, i_rst_n, r_out_valid && (r_out_entry.sum == '0), (r_out_entry.row == '0), "dark column reports a nonzero row")

endmodule

`default_nettype wire
